@@ design/mde_pkg.sv @@
// ----------------------------------------------------------------------------
// mde_pkg
// Shared types and codes for the multiply/divide instruction emulator.
// ----------------------------------------------------------------------------
package mde_pkg;

  localparam int unsigned FieldWidth   = 32;
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned QueueDepth   = 2;

  localparam logic [4:0] CauseIllegal = 5'd2;
  localparam logic [6:0] OpcRegReg    = 7'h33;
  localparam logic [6:0] F7MulDiv     = 7'h01;
  localparam logic [2:0] F3Mul        = 3'd0;
  localparam logic [2:0] F3Div        = 3'd4;
  localparam logic [2:0] F3Divu       = 3'd5;
  localparam logic [2:0] F3Rem        = 3'd6;
  localparam logic [2:0] F3Remu       = 3'd7;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_MUL  = 3'd1,
    OP_DIV  = 3'd2,
    OP_DIVU = 3'd3,
    OP_REM  = 3'd4,
    OP_REMU = 3'd5
  } op_e;

  typedef struct packed {
    logic [4:0]                   trap_cause;
    logic [FieldWidth-1:0]        instruction_word;
    logic signed [FieldWidth-1:0] rs1_value;
    logic signed [FieldWidth-1:0] rs2_value;
  } in_t;

  typedef struct packed {
    logic                         handled;
    logic [4:0]                   dest_index;
    logic signed [FieldWidth-1:0] write_value;
  } out_t;

  // classified command between front and back
  typedef struct packed {
    op_e                   op;
    logic [4:0]            rd;
    logic                  dz;
    logic                  ovf;
    logic [FieldWidth-1:0] a;
    logic [FieldWidth-1:0] b;
  } cmd_t;

endpackage

@@ design/mde_front.sv @@
// ----------------------------------------------------------------------------
// mde_front
// Decodes the trapped instruction and flags divide special cases.
// ----------------------------------------------------------------------------
module mde_front #(
  parameter int unsigned DataWidth = mde_pkg::DataWidthDef
) (
  input  mde_pkg::in_t  item_i,
  output mde_pkg::cmd_t cmd_o
);
  import mde_pkg::*;

  logic [6:0] opcode;
  logic [6:0] f7;
  logic [2:0] f3;
  logic       match;
  op_e        op;

  assign opcode = item_i.instruction_word[6:0];
  assign f3     = item_i.instruction_word[14:12];
  assign f7     = item_i.instruction_word[31:25];
  assign match  = (item_i.trap_cause == CauseIllegal) && (opcode == OpcRegReg) &&
                  (f7 == F7MulDiv);

  always_comb begin
    op = OP_NONE;
    if (match) begin
      unique case (f3)
        F3Mul:   op = OP_MUL;
        F3Div:   op = OP_DIV;
        F3Divu:  op = OP_DIVU;
        F3Rem:   op = OP_REM;
        F3Remu:  op = OP_REMU;
        default: op = OP_NONE;
      endcase
    end
  end

  assign cmd_o.op  = op;
  assign cmd_o.rd  = item_i.instruction_word[11:7];
  assign cmd_o.a   = item_i.rs1_value;
  assign cmd_o.b   = item_i.rs2_value;
  assign cmd_o.dz  = (item_i.rs2_value == '0);
  // most negative over -1 only exists when the datapath is as wide as the field
  assign cmd_o.ovf = (DataWidth == FieldWidth) &&
                     (item_i.rs1_value == {1'b1, {(FieldWidth-1){1'b0}}}) &&
                     (item_i.rs2_value == '1);

endmodule

@@ design/mde_queue.sv @@
// ----------------------------------------------------------------------------
// mde_queue
// Short command FIFO between front and back.
// ----------------------------------------------------------------------------
module mde_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mde_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output mde_pkg::cmd_t cmd_o,
  output logic          empty_o,
  output logic          full_o
);
  import mde_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ design/mde_back.sv @@
// ----------------------------------------------------------------------------
// mde_back
// Execution pipeline: operand setup and multiply, one restoring divide
// step per stage, then sign fix-up and result select.
// ----------------------------------------------------------------------------
module mde_back #(
  parameter int unsigned DataWidth = mde_pkg::DataWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  mde_pkg::cmd_t cmd_i,
  output logic          res_valid_o,
  output mde_pkg::out_t result_o
);
  import mde_pkg::*;

  typedef struct packed {
    op_e                   op;
    logic [4:0]            rd;
    logic                  dz;
    logic                  ovf;
    logic                  na;
    logic                  nb;
    logic [FieldWidth-1:0] a;
    logic [FieldWidth-1:0] prod;
    logic [DataWidth-1:0]  mb;
    logic [DataWidth-1:0]  rem;
    logic [DataWidth-1:0]  q;
  } stg_t;

  stg_t               stg_q [DataWidth+1];
  stg_t               stg_d [DataWidth+1];
  logic [DataWidth:0] vld_q;

  logic [DataWidth-1:0] aw;
  logic [DataWidth-1:0] bw;
  logic                 sgn;

  assign aw  = DataWidth'($signed(cmd_i.a));
  assign bw  = DataWidth'($signed(cmd_i.b));
  assign sgn = (cmd_i.op == OP_DIV) || (cmd_i.op == OP_REM);

  always_comb begin
    stg_d[0].op   = cmd_i.op;
    stg_d[0].rd   = cmd_i.rd;
    stg_d[0].dz   = cmd_i.dz;
    stg_d[0].ovf  = cmd_i.ovf;
    stg_d[0].na   = sgn && aw[DataWidth-1];
    stg_d[0].nb   = sgn && bw[DataWidth-1];
    stg_d[0].a    = cmd_i.a;
    stg_d[0].prod = cmd_i.a * cmd_i.b;
    stg_d[0].mb   = (sgn && bw[DataWidth-1]) ? '0 - bw : bw;
    stg_d[0].rem  = '0;
    stg_d[0].q    = (sgn && aw[DataWidth-1]) ? '0 - aw : aw;
  end

  for (genvar k = 0; k < DataWidth; k++) begin : g_step
    logic [DataWidth:0] t;
    logic [DataWidth:0] diff;

    assign t    = {stg_q[k].rem, stg_q[k].q[DataWidth-1]};
    assign diff = t - {1'b0, stg_q[k].mb};

    always_comb begin
      stg_d[k+1] = stg_q[k];
      if (!diff[DataWidth]) begin
        stg_d[k+1].rem = diff[DataWidth-1:0];
        stg_d[k+1].q   = {stg_q[k].q[DataWidth-2:0], 1'b1};
      end else begin
        stg_d[k+1].rem = t[DataWidth-1:0];
        stg_d[k+1].q   = {stg_q[k].q[DataWidth-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i <= DataWidth; i++) begin
      stg_q[i] <= stg_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DataWidth-1:0], valid_i};
    end
  end

  stg_t                 last;
  logic [DataWidth-1:0] qn;
  logic [DataWidth-1:0] rn;
  logic [FieldWidth-1:0] val;
  out_t                 res_d, res_q;
  logic                 res_valid_q;

  assign last = stg_q[DataWidth];
  assign qn   = (last.na != last.nb) ? '0 - last.q : last.q;
  assign rn   = last.na ? '0 - last.rem : last.rem;

  always_comb begin
    unique case (last.op)
      OP_MUL:  val = last.prod;
      OP_DIV:  val = last.dz ? '1 : (last.ovf ? last.a : qn[FieldWidth-1:0]);
      OP_DIVU: val = last.dz ? '1 : last.q[FieldWidth-1:0];
      OP_REM:  val = last.dz ? last.a : (last.ovf ? '0 : rn[FieldWidth-1:0]);
      OP_REMU: val = last.dz ? last.a : last.rem[FieldWidth-1:0];
      default: val = '0;
    endcase
    res_d.handled     = vld_q[DataWidth] && (last.op != OP_NONE);
    res_d.dest_index  = last.rd;
    res_d.write_value = val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= vld_q[DataWidth];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign result_o    = res_q;

endmodule

@@ design/muldiv_instruction_emulator.sv @@
// ----------------------------------------------------------------------------
// muldiv_instruction_emulator
// Emulates trapped MUL/DIV/DIVU/REM/REMU instructions in a pipeline.
//
//   channel   ports                     transfer when
//   command   start, busy, item_i       start high and busy low at clk_i rise
//   result    res_valid_o, result_o     res_valid_o high, one cycle per result
//
// One command per cycle. A command passes through the queue, then operand setup
// and the multiply, DataWidth restoring divide stages, and sign fix-up and select.
// Reset clears the queue and all stage valids; no clearing pass.
// The result side never stalls, so the back end drains the queue every cycle
// and busy stays low.
// ----------------------------------------------------------------------------
module muldiv_instruction_emulator #(
  parameter int unsigned DataWidth = mde_pkg::DataWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  mde_pkg::in_t  item_i,
  output logic          res_valid_o,
  output mde_pkg::out_t result_o
);
  import mde_pkg::*;

  localparam int unsigned Latency = DataWidth + 3;

  cmd_t fe_cmd;
  cmd_t q_cmd;
  logic q_empty;
  logic q_full;
  logic acc;

  assign busy = q_full;
  assign acc  = start && !busy;

  mde_front #(
    .DataWidth(DataWidth)
  ) u_front (
    .item_i(item_i),
    .cmd_o (fe_cmd)
  );

  mde_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (acc),
    .cmd_i  (fe_cmd),
    .pop_i  (!q_empty),
    .cmd_o  (q_cmd),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  mde_back #(
    .DataWidth(DataWidth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (!q_empty),
    .cmd_i      (q_cmd),
    .res_valid_o(res_valid_o),
    .result_o   (result_o)
  );

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(acc, Latency))
    else $error("result without a matching command");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("command queue backed up");

  a_handled_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.handled |-> res_valid_o)
    else $error("handled flag outside a result");

endmodule

@@ tb/sv/muldiv_instruction_emulator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// muldiv_instruction_emulator_tb
// Drives trapped instructions with operands into the emulator and checks
// every result in order against a local model of MUL, DIV, DIVU, REM and REMU
// that covers divide by zero, signed overflow and unsupported encodings.
// A directed set comes first, then constrained-by-hand random commands, with
// random gaps on the command side.
// ----------------------------------------------------------------------------
module muldiv_instruction_emulator_tb;
  import mde_pkg::*;

  localparam logic [2:0] F3Mulh   = 3'd1;
  localparam logic [2:0] F3Mulhsu = 3'd2;
  localparam logic [2:0] F3Mulhu  = 3'd3;

  localparam int unsigned NumRandom   = 550;
  localparam int unsigned DrainCycles = DataWidthDef + 20;

  logic  clk_i  = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start  = 1'b0;
  logic  busy;
  in_t   item   = '0;
  logic  res_valid_o;
  out_t  result_o;

  in_t         cmd_queue[$];
  out_t        expected_results[$];
  int unsigned issued       = 0;
  int unsigned mismatch_cnt = 0;

  muldiv_instruction_emulator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item),
    .res_valid_o (res_valid_o),
    .result_o    (result_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic out_t emulate_insn(in_t cmd);
    out_t        r;
    logic [6:0]  opc;
    logic [6:0]  f7;
    logic [2:0]  f3;
    logic [31:0] a, b, q, rm, ma, mb;
    logic        na, nb;
    opc = cmd.instruction_word[6:0];
    f7  = cmd.instruction_word[31:25];
    f3  = cmd.instruction_word[14:12];
    a   = cmd.rs1_value;
    b   = cmd.rs2_value;
    r.handled     = 1'b0;
    r.dest_index  = cmd.instruction_word[11:7];
    r.write_value = '0;
    if (cmd.trap_cause == CauseIllegal && opc == OpcRegReg && f7 == F7MulDiv) begin
      case (f3)
        F3Mul: begin
          r.handled     = 1'b1;
          r.write_value = a * b;
        end
        F3Divu, F3Remu: begin
          if (b == '0) begin
            q  = '1;
            rm = a;
          end else begin
            q  = a / b;
            rm = a % b;
          end
          r.handled     = 1'b1;
          r.write_value = (f3 == F3Divu) ? q : rm;
        end
        F3Div, F3Rem: begin
          if (b == '0) begin
            q  = '1;
            rm = a;
          end else if (a == 32'h8000_0000 && b == '1) begin
            q  = a;
            rm = '0;
          end else begin
            na = a[31];
            nb = b[31];
            ma = na ? (~a + 32'd1) : a;
            mb = nb ? (~b + 32'd1) : b;
            q  = ma / mb;
            rm = ma % mb;
            if (na != nb) q = ~q + 32'd1;
            if (na) rm = ~rm + 32'd1;
          end
          r.handled     = 1'b1;
          r.write_value = (f3 == F3Div) ? q : rm;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic logic [31:0] make_insn(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                            logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic void queue_cmd(logic [4:0] cause, logic [31:0] insn,
                                    logic [31:0] a, logic [31:0] b);
    in_t c;
    c.trap_cause       = cause;
    c.instruction_word = insn;
    c.rs1_value        = a;
    c.rs2_value        = b;
    cmd_queue.push_back(c);
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'($urandom_range(15));
      5: return 32'd0 - 32'($urandom_range(15));
      6: return 32'($urandom_range(65535));
      default: return $urandom;
    endcase
  endfunction

  // driver: pops a command per transfer, random gaps except in a burst window
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_results.push_back(emulate_insn(item));
      if (!start || !busy) begin
        if (cmd_queue.size() != 0 &&
            ($urandom_range(99) >= 31 || (issued >= 250 && issued < 400))) begin
          item   <= cmd_queue.pop_front();
          start  <= 1'b1;
          issued <= issued + 1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results arrive in command order
  always @(posedge clk_i) begin
    out_t exp_res;
    if (rst_ni && res_valid_o) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: handled=%0d rd=%0d value=%h",
               result_o.handled, result_o.dest_index, result_o.write_value);
        mismatch_cnt = mismatch_cnt + 1;
      end else begin
        exp_res = expected_results.pop_front();
        if (result_o.handled !== exp_res.handled) begin
          $error("handled: expected %0d, actual %0d", exp_res.handled, result_o.handled);
          mismatch_cnt = mismatch_cnt + 1;
        end
        if (result_o.dest_index !== exp_res.dest_index) begin
          $error("dest_index: expected %0d, actual %0d",
                 exp_res.dest_index, result_o.dest_index);
          mismatch_cnt = mismatch_cnt + 1;
        end
        if (result_o.write_value !== exp_res.write_value) begin
          $error("write_value: expected %h, actual %h",
                 exp_res.write_value, result_o.write_value);
          mismatch_cnt = mismatch_cnt + 1;
        end
      end
    end
  end

  initial begin
    logic [4:0]  cause;
    logic [31:0] insn;

    // directed: extremes, each operation, zero divisor, overflow, unsupported
    queue_cmd(CauseIllegal, make_insn(F7MulDiv, 5'd2, 5'd1, F3Mul, 5'd31, OpcRegReg),
              32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_cmd(CauseIllegal, make_insn(F7MulDiv, 5'd2, 5'd1, F3Mul, 5'd0, OpcRegReg),
              32'h8000_0000, 32'hFFFF_FFFF);
    queue_cmd(CauseIllegal, make_insn(F7MulDiv, 5'd31, 5'd31, F3Mul, 5'd5, OpcRegReg),
              32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(CauseIllegal, make_insn(F7MulDiv, 5'd2, 5'd1, F3Div, 5'd3, OpcRegReg),
              32'd7, 32'hFFFF_FFFE);
    queue_cmd(CauseIllegal, make_insn(F7MulDiv, 5'd2, 5'd1, F3Div, 5'd3, OpcRegReg),
              32'hFFFF_FFF9, 32'd2);
    queue_cmd(CauseIllegal, make_insn(F7MulDiv, 5'd2, 5'd1, F3Div, 5'd3, OpcRegReg),
              32'hFFFF_FFF9, 32'hFFFF_FFFE);
    queue_cmd(CauseIllegal, make_insn(F7MulDiv, 5'd2, 5'd1, F3Div, 5'd4, OpcRegReg),
              32'h1234_5678, 32'd0);
    queue_cmd(CauseIllegal, make_insn(F7MulDiv, 5'd2, 5'd1, F3Div, 5'd4, OpcRegReg),
              32'h8000_0000, 32'hFFFF_FFFF);
    queue_cmd(CauseIllegal, make_insn(F7MulDiv, 5'd2, 5'd1, F3Rem, 5'd6, OpcRegReg),
              32'hFFFF_FFF9, 32'd2);
    queue_cmd(CauseIllegal, make_insn(F7MulDiv, 5'd2, 5'd1, F3Rem, 5'd6, OpcRegReg),
              32'd7, 32'hFFFF_FFFE);
    queue_cmd(CauseIllegal, make_insn(F7MulDiv, 5'd2, 5'd1, F3Rem, 5'd6, OpcRegReg),
              32'h8765_4321, 32'd0);
    queue_cmd(CauseIllegal, make_insn(F7MulDiv, 5'd2, 5'd1, F3Rem, 5'd6, OpcRegReg),
              32'h8000_0000, 32'hFFFF_FFFF);
    queue_cmd(CauseIllegal, make_insn(F7MulDiv, 5'd2, 5'd1, F3Divu, 5'd7, OpcRegReg),
              32'hFFFF_FFFF, 32'd2);
    queue_cmd(CauseIllegal, make_insn(F7MulDiv, 5'd2, 5'd1, F3Divu, 5'd7, OpcRegReg),
              32'h8000_0000, 32'd0);
    queue_cmd(CauseIllegal, make_insn(F7MulDiv, 5'd2, 5'd1, F3Remu, 5'd8, OpcRegReg),
              32'hFFFF_FFFF, 32'h8000_0000);
    queue_cmd(CauseIllegal, make_insn(F7MulDiv, 5'd2, 5'd1, F3Remu, 5'd8, OpcRegReg),
              32'hFFFF_FFFF, 32'd0);
    queue_cmd(CauseIllegal, make_insn(F7MulDiv, 5'd2, 5'd1, F3Mulh, 5'd9, OpcRegReg),
              32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_cmd(CauseIllegal, make_insn(F7MulDiv, 5'd2, 5'd1, F3Mulhsu, 5'd10, OpcRegReg),
              32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(CauseIllegal, make_insn(F7MulDiv, 5'd2, 5'd1, F3Mulhu, 5'd11, OpcRegReg),
              32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(5'd31, make_insn(F7MulDiv, 5'd2, 5'd1, F3Mul, 5'd12, OpcRegReg),
              32'd3, 32'd4);
    queue_cmd(5'd0, make_insn(F7MulDiv, 5'd2, 5'd1, F3Div, 5'd13, OpcRegReg),
              32'd9, 32'd3);
    queue_cmd(CauseIllegal, make_insn(F7MulDiv, 5'd2, 5'd1, F3Mul, 5'd14, 7'h3B),
              32'd3, 32'd4);
    queue_cmd(CauseIllegal, make_insn(7'h20, 5'd2, 5'd1, F3Div, 5'd15, OpcRegReg),
              32'd9, 32'd3);
    queue_cmd(CauseIllegal, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(CauseIllegal, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

    // random: mostly well-formed M-extension encodings, some noise
    for (int i = 0; i < NumRandom; i++) begin
      if ($urandom_range(99) < 85)
        insn = make_insn(F7MulDiv, 5'($urandom), 5'($urandom), 3'($urandom),
                         5'($urandom), OpcRegReg);
      else
        insn = $urandom;
      cause = ($urandom_range(99) < 85) ? CauseIllegal : 5'($urandom);
      queue_cmd(cause, insn, pick_operand(), pick_operand());
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_queue.size() != 0 || start) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
